>>> rtl/ppac_pkg.sv
// Shared types, source format codes and arithmetic helpers for the packed
// pixel to ARGB32 converter. No dependencies; every rtl module imports it.
`timescale 1ns / 1ps

package ppac_pkg;

    localparam int unsigned PixelWidth = 32;
    localparam logic [7:0]  AlphaFull  = 8'hFF;

    // BT.601 coefficients, scaled by 1000.
    localparam logic [10:0] CoefRv = 11'd1402;
    localparam logic [8:0]  CoefGu = 9'd344;
    localparam logic [9:0]  CoefGv = 10'd714;
    localparam logic [10:0] CoefBu = 11'd1772;

    // Unsigned division by 1000 of an 18-bit magnitude as a multiply by
    // ceil(2^28 / 1000) and a shift. The result is exact below about 4.9e5.
    localparam int unsigned RecipShift = 28;
    localparam logic [18:0] Recip1000  = 19'd268436;

    // 5-bit and 6-bit color expansion: c*255/31 and c*255/63 as a multiply
    // by a scaled reciprocal and a shift by 20.
    localparam logic [23:0] Expand5Mul = 24'd8625630;
    localparam logic [22:0] Expand6Mul = 23'd4244475;

    typedef enum logic [2:0] {
        FMT_ARGB32 = 3'd0,
        FMT_RGB32  = 3'd1,
        FMT_BGR32  = 3'd2,
        FMT_RGB24  = 3'd3,
        FMT_BGR24  = 3'd4,
        FMT_RGB565 = 3'd5,
        FMT_YUYV   = 3'd6,
        FMT_UYVY   = 3'd7
    } src_fmt_t;

    // Stage 1 result: the finished pixel for direct formats, or the split
    // luma and chroma fields for the YUV formats.
    typedef struct packed {
        logic                  is_yuv;
        logic                  want2;
        logic [PixelWidth-1:0] direct_pix;
        logic [7:0]            y0;
        logic [7:0]            y1;
        logic                  u_neg;
        logic [7:0]            u_mag;
        logic                  v_neg;
        logic [7:0]            v_mag;
    } unpack_t;

    // Chroma contribution magnitudes, with the sign of the chroma sample.
    typedef struct packed {
        logic        u_neg;
        logic        v_neg;
        logic [17:0] rv;
        logic [17:0] gu;
        logic [17:0] gv;
        logic [17:0] bu;
    } chroma_t;

    // Chroma terms after division by 1000.
    typedef struct packed {
        logic       u_neg;
        logic       v_neg;
        logic [7:0] rv;
        logic [7:0] gu;
        logic [7:0] gv;
        logic [7:0] bu;
    } term_t;

    // Luma, pixel mode and direct pixel that ride along with the chroma work.
    typedef struct packed {
        logic                  is_yuv;
        logic                  want2;
        logic [PixelWidth-1:0] direct_pix;
        logic [7:0]            y0;
        logic [7:0]            y1;
    } side_t;

    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [27:0] p;
        begin
            p = 28'(c * Expand5Mul);
            return p[27:20];
        end
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [27:0] p;
        begin
            p = 28'(c * Expand6Mul);
            return p[27:20];
        end
    endfunction

    function automatic logic signed [10:0] signed_term(input logic neg,
                                                      input logic [7:0] q);
        logic signed [10:0] t;
        begin
            t = $signed({3'b000, q});
            return neg ? -t : t;
        end
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [10:0] x);
        begin
            if (x < 0) begin
                return 8'd0;
            end
            if (x > 11'sd255) begin
                return 8'd255;
            end
            return x[7:0];
        end
    endfunction

endpackage

>>> rtl/packed_pixel_to_argb32_converter.sv
// Top level of the packed pixel to ARGB32 converter: configuration register,
// pipeline control and the four pipeline stages. Depends on ppac_pkg and all
// ppac_* modules.
`timescale 1ns / 1ps

// One source unit enters per clock while the pipeline is not held, so
// throughput is one transaction per cycle without stalls. Stage 1 unpacks the unit by
// format, stage 2 forms the BT.601 chroma products, stage 3 divides them by
// 1000 through reciprocal multipliers, and stage 4 adds luma, clamps and
// holds the result in the output register. When m_tready is low with a
// result waiting, the whole pipeline holds and s_tready drops in the same
// cycle; no bubble is lost. Write source_format only while the pipeline is
// empty.
module packed_pixel_to_argb32_converter
    import ppac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // byte0, byte1, byte2, byte3
    input  logic        s_tuser,   // second_wanted

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pixel_first, pixel_second
    output logic        m_tuser    // second_valid
);

    localparam logic RegSourceFormat = 1'b0;

    src_fmt_t fmt_reg;
    logic     en;

    logic    s1_valid;
    unpack_t s1_data;
    logic    s3_valid;
    term_t   s3_term;
    side_t   s3_side;
    logic    out_valid;
    logic [PixelWidth-1:0] pix_first;
    logic [PixelWidth-1:0] pix_second;
    logic    pix_second_valid;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fmt_reg <= FMT_ARGB32;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == RegSourceFormat) begin
            fmt_reg <= src_fmt_t'(pwdata[2:0]);
        end
    end

    assign prdata = (paddr[2] == RegSourceFormat) ? {29'd0, fmt_reg} : 32'd0;

    // Every stage advances unless a finished result is waiting downstream.
    assign en       = !out_valid || m_tready;
    assign s_tready = en;

    ppac_unpack u_unpack (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .fmt       (fmt_reg),
        .in_valid  (s_tvalid),
        .b0        (s_tdata[7:0]),
        .b1        (s_tdata[15:8]),
        .b2        (s_tdata[23:16]),
        .b3        (s_tdata[31:24]),
        .want2     (s_tuser),
        .out_valid (s1_valid),
        .out_data  (s1_data)
    );

    ppac_chroma u_chroma (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .in_data   (s1_data),
        .out_valid (s3_valid),
        .out_term  (s3_term),
        .out_side  (s3_side)
    );

    ppac_assemble u_assemble (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (s3_valid),
        .in_term      (s3_term),
        .in_side      (s3_side),
        .out_valid    (out_valid),
        .pixel_first  (pix_first),
        .pixel_second (pix_second),
        .second_valid (pix_second_valid)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {pix_second, pix_first};
    assign m_tuser  = pix_second_valid;

endmodule

>>> rtl/ppac_unpack.sv
// Stage 1: splits a source unit by format. Builds the pixel for the direct
// formats and the luma and chroma fields for YUV. Depends on ppac_pkg.
`timescale 1ns / 1ps

module ppac_unpack
    import ppac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  src_fmt_t   fmt,
    input  logic       in_valid,
    input  logic [7:0] b0,
    input  logic [7:0] b1,
    input  logic [7:0] b2,
    input  logic [7:0] b3,
    input  logic       want2,
    output logic       out_valid,
    output unpack_t    out_data
);

    logic    valid_reg;
    logic    valid_next;
    unpack_t data_reg;
    unpack_t data_next;
    logic [7:0] u_raw;
    logic [7:0] v_raw;

    always_comb
    begin
        data_next        = '0;
        data_next.want2  = want2;
        u_raw            = b1;
        v_raw            = b3;
        unique case (fmt)
            FMT_ARGB32:
            begin
                data_next.direct_pix = {b3, b2, b1, b0};
            end
            FMT_RGB32:
            begin
                data_next.direct_pix = {AlphaFull, b2, b1, b0};
            end
            FMT_BGR32, FMT_BGR24:
            begin
                data_next.direct_pix = {AlphaFull, b2, b1, b0};
            end
            FMT_RGB24:
            begin
                data_next.direct_pix = {AlphaFull, b0, b1, b2};
            end
            FMT_RGB565:
            begin
                data_next.direct_pix = {AlphaFull, expand5(b1[7:3]),
                                        expand6({b1[2:0], b0[7:5]}),
                                        expand5(b0[4:0])};
            end
            FMT_YUYV:
            begin
                data_next.is_yuv = 1'b1;
                data_next.y0     = b0;
                data_next.y1     = b2;
                u_raw            = b1;
                v_raw            = b3;
            end
            FMT_UYVY:
            begin
                data_next.is_yuv = 1'b1;
                data_next.y0     = b1;
                data_next.y1     = b3;
                u_raw            = b0;
                v_raw            = b2;
            end
            default:
            begin
                data_next.direct_pix = '0;
            end
        endcase
        // Chroma is offset by 128; keep it as sign and magnitude (at most 128).
        data_next.u_neg = ~u_raw[7];
        data_next.u_mag = u_raw[7] ? {1'b0, u_raw[6:0]} : 8'd128 - u_raw;
        data_next.v_neg = ~v_raw[7];
        data_next.v_mag = v_raw[7] ? {1'b0, v_raw[6:0]} : 8'd128 - v_raw;
    end

    assign valid_next = in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/ppac_chroma.sv
// Stages 2 and 3: BT.601 chroma products and their division by 1000
// through a reciprocal multiply. Depends on ppac_pkg.
`timescale 1ns / 1ps

module ppac_chroma
    import ppac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  unpack_t in_data,
    output logic    out_valid,
    output term_t   out_term,
    output side_t   out_side
);

    logic    prod_valid_reg;
    chroma_t prod_reg;
    chroma_t prod_next;
    side_t   prod_side_reg;
    side_t   prod_side_next;

    logic    quot_valid_reg;
    term_t   quot_reg;
    term_t   quot_next;
    side_t   quot_side_reg;

    logic [36:0] q_rv;
    logic [36:0] q_gu;
    logic [36:0] q_gv;
    logic [36:0] q_bu;

    always_comb
    begin
        prod_next.u_neg = in_data.u_neg;
        prod_next.v_neg = in_data.v_neg;
        prod_next.rv    = 18'(in_data.v_mag * CoefRv);
        prod_next.gu    = 18'(in_data.u_mag * CoefGu);
        prod_next.gv    = 18'(in_data.v_mag * CoefGv);
        prod_next.bu    = 18'(in_data.u_mag * CoefBu);

        prod_side_next.is_yuv     = in_data.is_yuv;
        prod_side_next.want2      = in_data.want2;
        prod_side_next.direct_pix = in_data.direct_pix;
        prod_side_next.y0         = in_data.y0;
        prod_side_next.y1         = in_data.y1;
    end

    // Dividing magnitudes truncates toward zero, as the sign is applied later.
    always_comb
    begin
        q_rv = 37'(prod_reg.rv * Recip1000);
        q_gu = 37'(prod_reg.gu * Recip1000);
        q_gv = 37'(prod_reg.gv * Recip1000);
        q_bu = 37'(prod_reg.bu * Recip1000);

        quot_next.u_neg = prod_reg.u_neg;
        quot_next.v_neg = prod_reg.v_neg;
        quot_next.rv    = q_rv[RecipShift+7:RecipShift];
        quot_next.gu    = q_gu[RecipShift+7:RecipShift];
        quot_next.gv    = q_gv[RecipShift+7:RecipShift];
        quot_next.bu    = q_bu[RecipShift+7:RecipShift];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prod_valid_reg <= 1'b0;
            quot_valid_reg <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= in_valid;
            quot_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            prod_reg      <= prod_next;
            prod_side_reg <= prod_side_next;
            quot_reg      <= quot_next;
            quot_side_reg <= prod_side_reg;
        end
    end

    assign out_valid = quot_valid_reg;
    assign out_term  = quot_reg;
    assign out_side  = quot_side_reg;

endmodule

>>> rtl/ppac_assemble.sv
// Stage 4: adds the chroma terms to each YUV luma sample, clamps and packs the
// result, or the direct pixel, into the output register. Depends on ppac_pkg.
`timescale 1ns / 1ps

module ppac_assemble
    import ppac_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  term_t                 in_term,
    input  side_t                 in_side,
    output logic                  out_valid,
    output logic [PixelWidth-1:0] pixel_first,
    output logic [PixelWidth-1:0] pixel_second,
    output logic                  second_valid
);

    logic                  valid_reg;
    logic [PixelWidth-1:0] first_reg;
    logic [PixelWidth-1:0] first_next;
    logic [PixelWidth-1:0] second_reg;
    logic [PixelWidth-1:0] second_next;
    logic                  svalid_reg;
    logic                  svalid_next;

    logic signed [10:0] t_r;
    logic signed [10:0] t_g;
    logic signed [10:0] t_b;
    logic signed [10:0] y0_s;
    logic signed [10:0] y1_s;
    logic [PixelWidth-1:0] yuv0;
    logic [PixelWidth-1:0] yuv1;

    always_comb
    begin
        t_r  = signed_term(in_term.v_neg, in_term.rv);
        t_g  = -signed_term(in_term.u_neg, in_term.gu)
               - signed_term(in_term.v_neg, in_term.gv);
        t_b  = signed_term(in_term.u_neg, in_term.bu);
        y0_s = $signed({3'b000, in_side.y0});
        y1_s = $signed({3'b000, in_side.y1});

        yuv0 = {AlphaFull, clamp8(y0_s + t_r), clamp8(y0_s + t_g), clamp8(y0_s + t_b)};
        yuv1 = {AlphaFull, clamp8(y1_s + t_r), clamp8(y1_s + t_g), clamp8(y1_s + t_b)};

        if (in_side.is_yuv) begin
            first_next  = yuv0;
            second_next = in_side.want2 ? yuv1 : '0;
            svalid_next = in_side.want2;
        end else begin
            first_next  = in_side.direct_pix;
            second_next = '0;
            svalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            first_reg  <= first_next;
            second_reg <= second_next;
            svalid_reg <= svalid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign pixel_first  = first_reg;
    assign pixel_second = second_reg;
    assign second_valid = svalid_reg;

endmodule
